[rtl/qcc_pkg.sv]
// Package for the quadrature cycle counter: shared types, opcodes,
// configuration indexes and the phase tracking tables.
// Depends on nothing.
package qcc_pkg;

    localparam int CountWidth = 16;
    localparam int PhaseWidth = 3;
    localparam int SelWidth   = 3;
    localparam int CfgIdxWidth = 2;
    localparam int NumStates  = 5;

    typedef enum logic [1:0] {
        OP_UPDATE = 2'd0,
        OP_INIT   = 2'd1,
        OP_LOAD   = 2'd2,
        OP_NONE   = 2'd3
    } t_opcode;

    typedef enum logic [CfgIdxWidth-1:0] {
        CFG_BIT_A_SELECT = 2'd0,
        CFG_BIT_B_SELECT = 2'd1,
        CFG_COUNT_MIN    = 2'd2,
        CFG_COUNT_MAX    = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic [SelWidth-1:0]          bit_a_select;
        logic [SelWidth-1:0]          bit_b_select;
        logic signed [CountWidth-1:0] count_min;
        logic signed [CountWidth-1:0] count_max;
    } t_cfg;

    typedef struct packed {
        logic signed [CountWidth-1:0] count;
        logic [PhaseWidth-1:0]        phase;
    } t_state;

    localparam logic [SelWidth-1:0]          BitASelectReset = 3'd0;
    localparam logic [SelWidth-1:0]          BitBSelectReset = 3'd1;
    localparam logic signed [CountWidth-1:0] CountMinReset   = 16'sh8000;
    localparam logic signed [CountWidth-1:0] CountMaxReset   = 16'sh7FFF;
    localparam logic [PhaseWidth-1:0]        PhaseReset      = 3'd1;
    localparam logic [PhaseWidth-1:0]        PhaseMissed     = 3'd0;

    typedef logic [PhaseWidth-1:0] t_phase_row [4];
    typedef logic signed [1:0]     t_step_row [4];

    localparam t_phase_row NextPhase [NumStates] = '{
        '{3'd1, 3'd2, 3'd4, 3'd3},
        '{3'd1, 3'd2, 3'd4, 3'd0},
        '{3'd1, 3'd2, 3'd0, 3'd3},
        '{3'd0, 3'd2, 3'd4, 3'd3},
        '{3'd1, 3'd0, 3'd4, 3'd3}
    };

    localparam t_step_row CountStep [NumStates] = '{
        '{2'sd0,  2'sd0, 2'sd0,  2'sd0},
        '{2'sd0,  2'sd0, -2'sd1, 2'sd0},
        '{2'sd0,  2'sd0, 2'sd0,  2'sd0},
        '{2'sd0,  2'sd0, 2'sd0,  2'sd0},
        '{2'sd1,  2'sd0, 2'sd0,  2'sd0}
    };

endpackage

[rtl/qcc_cfg.sv]
// Configuration register file of the quadrature cycle counter.
// Depends on qcc_pkg.
module qcc_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [qcc_pkg::CfgIdxWidth-1:0]  i_cfg_index,
    input  logic [qcc_pkg::CountWidth-1:0]   i_cfg_data,
    output qcc_pkg::t_cfg                    o_cfg
);

    qcc_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bit_a_select <= qcc_pkg::BitASelectReset;
            r_cfg.bit_b_select <= qcc_pkg::BitBSelectReset;
            r_cfg.count_min    <= qcc_pkg::CountMinReset;
            r_cfg.count_max    <= qcc_pkg::CountMaxReset;
        end else if (i_cfg_we) begin
            unique case (qcc_pkg::t_cfg_index'(i_cfg_index))
                qcc_pkg::CFG_BIT_A_SELECT: begin
                    r_cfg.bit_a_select <= i_cfg_data[qcc_pkg::SelWidth-1:0];
                end
                qcc_pkg::CFG_BIT_B_SELECT: begin
                    r_cfg.bit_b_select <= i_cfg_data[qcc_pkg::SelWidth-1:0];
                end
                qcc_pkg::CFG_COUNT_MIN: begin
                    r_cfg.count_min <= i_cfg_data;
                end
                qcc_pkg::CFG_COUNT_MAX: begin
                    r_cfg.count_max <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/qcc_step.sv]
// Next-state logic of the quadrature cycle counter: quadrant extraction,
// phase table lookup and saturating count update. Depends on qcc_pkg.
module qcc_step (
    input  qcc_pkg::t_cfg                        i_cfg,
    input  qcc_pkg::t_state                      i_state,
    input  logic [1:0]                           i_opcode,
    input  logic [7:0]                           i_port_byte,
    input  logic signed [qcc_pkg::CountWidth-1:0] i_load_value,
    output qcc_pkg::t_state                      o_state
);

    localparam int SumWidth = qcc_pkg::CountWidth + 1;

    logic [1:0]                        quad;
    logic [qcc_pkg::PhaseWidth-1:0]    cur;
    logic [qcc_pkg::PhaseWidth-1:0]    np;
    logic signed [1:0]                 step;
    logic signed [SumWidth-1:0]        sum;
    logic signed [SumWidth-1:0]        clamp_in;
    logic signed [SumWidth-1:0]        lo_clamped;
    logic signed [SumWidth-1:0]        clamped;
    logic signed [SumWidth-1:0]        min_ext;
    logic signed [SumWidth-1:0]        max_ext;

    always_comb begin
        quad = {i_port_byte[i_cfg.bit_b_select], i_port_byte[i_cfg.bit_a_select]};
        cur  = (i_state.phase <= 3'd4) ? i_state.phase : qcc_pkg::PhaseMissed;
        np   = qcc_pkg::NextPhase[cur][quad];
        if (np == qcc_pkg::PhaseMissed) begin
            np = qcc_pkg::NextPhase[qcc_pkg::PhaseMissed][quad];
        end
        step    = qcc_pkg::CountStep[cur][quad];
        sum     = SumWidth'(i_state.count) + SumWidth'(step);
        min_ext = SumWidth'(i_cfg.count_min);
        max_ext = SumWidth'(i_cfg.count_max);

        clamp_in = (qcc_pkg::t_opcode'(i_opcode) == qcc_pkg::OP_LOAD)
                   ? SumWidth'(i_load_value) : sum;
        lo_clamped = (clamp_in < min_ext) ? min_ext : clamp_in;
        clamped    = (lo_clamped > max_ext) ? max_ext : lo_clamped;

        o_state = i_state;
        case (qcc_pkg::t_opcode'(i_opcode))
            qcc_pkg::OP_UPDATE: begin
                o_state.count = clamped[qcc_pkg::CountWidth-1:0];
                o_state.phase = np;
            end
            qcc_pkg::OP_INIT: begin
                o_state.count = '0;
                o_state.phase = qcc_pkg::NextPhase[qcc_pkg::PhaseMissed][quad];
            end
            qcc_pkg::OP_LOAD: begin
                o_state.count = clamped[qcc_pkg::CountWidth-1:0];
            end
            default: begin
            end
        endcase
    end

endmodule

[rtl/quadrature_cycle_counter_core.sv]
// Quadrature cycle counter: stream in sampled port bytes, stream out the
// full-cycle count and phase after each transaction.
// Channels: s_axis carries one transaction per sample; s_axis_tuser is the
// opcode (update, initialise, load, no-op) and s_axis_tdata holds the port
// byte and the load value. m_axis returns one transaction per input
// transaction with the count and the quadrant state.
// Throughput is one transaction per cycle while the receiver does not stall;
// the result appears on m_axis in the cycle after acceptance. The phase and
// count registers double as the result register, so the table lookup plus
// saturating add sets the rate. Configuration is written through i_cfg_we /
// i_cfg_index / i_cfg_data while the stream is idle.
// Reset clears the result valid, returns the phase to quadrant 00, the count
// to zero and the registers to their defaults.
// When the receiver stalls, s_axis_tready drops until the pending result is
// taken; a new transaction is accepted in the same cycle the result leaves.
// Depends on qcc_pkg, qcc_cfg and qcc_step.
module quadrature_cycle_counter_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [qcc_pkg::CfgIdxWidth-1:0]  i_cfg_index,
    input  logic [qcc_pkg::CountWidth-1:0]   i_cfg_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // Bits 7:0 port_byte, 23:8 load_value.
    input  logic [23:0]                      s_axis_tdata,
    // Bits 1:0 opcode.
    input  logic [1:0]                       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // Bits 15:0 cycle_count, 18:16 phase_state, 23:19 zero.
    output logic [23:0]                      m_axis_tdata
);

    qcc_pkg::t_cfg   cfg;
    qcc_pkg::t_state r_state;
    qcc_pkg::t_state n_state;
    logic            r_out_valid;
    logic            accept;

    qcc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    qcc_step u_step (
        .i_cfg        (cfg),
        .i_state      (r_state),
        .i_opcode     (s_axis_tuser),
        .i_port_byte  (s_axis_tdata[7:0]),
        .i_load_value (s_axis_tdata[23:8]),
        .o_state      (n_state)
    );

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid   <= 1'b0;
            r_state.count <= '0;
            r_state.phase <= qcc_pkg::PhaseReset;
        end else begin
            if (accept) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_state.phase, r_state.count};

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase != qcc_pkg::PhaseMissed && r_state.phase <= 3'd4)
        else $error("phase register left the quadrant range");

    a_accept_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> m_axis_tvalid)
        else $error("accepted transaction produced no result");

    a_init_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && s_axis_tuser == qcc_pkg::OP_INIT) |=> r_state.count == '0)
        else $error("initialise did not clear the count");

    a_hold_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> $stable(r_state))
        else $error("state changed without an accepted transaction");

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for quadrature_cycle_counter_core: a directed table and
// random encoder walks under several register settings, checked against a predictor.
// Depends on qcc_pkg and the RTL of quadrature_cycle_counter_core.
module testbench;

    localparam int NumDirected = 23;
    localparam int NumPhases = 12;
    localparam int ItemsPerPhase = 78;
    localparam int WatchdogLimit = 5000;
    localparam int HoldCycles = 200;

    typedef struct packed {
        qcc_pkg::t_opcode op;
        logic [7:0]       port;
        logic [15:0]      load;
        logic             typed;
        qcc_pkg::t_state  want;
    } t_vector;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;

    // Register copies and state of the predictor.
    logic [2:0]  sel_a = 3'd0;
    logic [2:0]  sel_b = 3'd1;
    int          lo_bound = -32768;
    int          hi_bound = 32767;
    logic [2:0]  cur_phase = 3'd1;
    int          cur_count = 0;

    qcc_pkg::t_state pending_counts[$];
    t_vector     directed_tbl [NumDirected];
    int          mismatches = 0;
    int          idle_cycles = 0;
    int          walk_pos = 0;
    bit          tx_idle = 1'b1;
    bit          rx_idle = 1'b1;
    bit          hold_req = 1'b0;

    quadrature_cycle_counter_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [2:0] phase_after(logic [2:0] p, logic [1:0] q);
        logic [11:0] row;
        case (p)
            3'd1: row = {3'd0, 3'd4, 3'd2, 3'd1};
            3'd2: row = {3'd3, 3'd0, 3'd2, 3'd1};
            3'd3: row = {3'd3, 3'd4, 3'd2, 3'd0};
            3'd4: row = {3'd3, 3'd4, 3'd0, 3'd1};
            default: row = {3'd3, 3'd4, 3'd2, 3'd1};
        endcase
        return row[q * 3 +: 3];
    endfunction

    function automatic int saturate(int v);
        int r;
        r = v;
        if (r < lo_bound) r = lo_bound;
        if (r > hi_bound) r = hi_bound;
        return r;
    endfunction

    function automatic logic [1:0] quadrant_at(int pos);
        case (pos)
            0: return 2'd0;
            1: return 2'd1;
            2: return 2'd3;
            default: return 2'd2;
        endcase
    endfunction

    task automatic advance_counter(input qcc_pkg::t_opcode op, input logic [7:0] port,
                                   input logic [15:0] load, output qcc_pkg::t_state res);
        logic [1:0] q;
        logic [2:0] p;
        logic [2:0] np;
        int step;
        q = {port[sel_b], port[sel_a]};
        p = (cur_phase <= 3'd4) ? cur_phase : 3'd0;
        case (op)
            qcc_pkg::OP_UPDATE: begin
                step = 0;
                if (p == 3'd1 && q == 2'd2) step = -1;
                if (p == 3'd4 && q == 2'd0) step = 1;
                np = phase_after(p, q);
                if (np == 3'd0) np = phase_after(3'd0, q);
                cur_phase = np;
                cur_count = saturate(cur_count + step);
            end
            qcc_pkg::OP_INIT: begin
                cur_count = 0;
                cur_phase = phase_after(3'd0, q);
            end
            qcc_pkg::OP_LOAD: begin
                cur_count = saturate($signed(load));
            end
            default: begin
            end
        endcase
        res.count = cur_count[15:0];
        res.phase = cur_phase;
    endtask

    task automatic write_reg(input qcc_pkg::t_cfg_index idx, input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        case (idx)
            qcc_pkg::CFG_BIT_A_SELECT: sel_a = val[2:0];
            qcc_pkg::CFG_BIT_B_SELECT: sel_b = val[2:0];
            qcc_pkg::CFG_COUNT_MIN:    lo_bound = $signed(val);
            default:                   hi_bound = $signed(val);
        endcase
    endtask

    task automatic configure(input int a, input int b, input int lo, input int hi);
        write_reg(qcc_pkg::CFG_BIT_A_SELECT, 16'(a));
        write_reg(qcc_pkg::CFG_BIT_B_SELECT, 16'(b));
        write_reg(qcc_pkg::CFG_COUNT_MIN, 16'(lo));
        write_reg(qcc_pkg::CFG_COUNT_MAX, 16'(hi));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_sample(input qcc_pkg::t_opcode op, input logic [7:0] port,
                               input logic [15:0] load, input logic typed,
                               input qcc_pkg::t_state want);
        int gap;
        qcc_pkg::t_state predicted;
        gap = tx_idle ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {load, port};
        s_axis_tuser <= op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        advance_counter(op, port, load, predicted);
        pending_counts.push_back(typed ? want : predicted);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_counts.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic make_sample(output qcc_pkg::t_opcode op, output logic [7:0] port,
                               output logic [15:0] load);
        int r;
        int move;
        logic [1:0] q;
        logic [7:0] pb;
        r = $urandom_range(0, 99);
        pb = 8'($urandom_range(0, 255));
        load = 16'($urandom_range(0, 65535));
        op = qcc_pkg::OP_UPDATE;
        if (r < 75) begin
            move = $urandom_range(0, 9);
            if (move >= 1 && move <= 4) walk_pos = (walk_pos + 1) % 4;
            else if (move >= 5 && move <= 8) walk_pos = (walk_pos + 3) % 4;
            else if (move == 9) walk_pos = (walk_pos + 2) % 4;
            q = quadrant_at(walk_pos);
            pb[sel_a] = q[0];
            pb[sel_b] = q[1];
        end else if (r < 85) begin
            op = qcc_pkg::OP_UPDATE;
        end else if (r < 90) begin
            op = qcc_pkg::OP_INIT;
        end else if (r < 96) begin
            op = qcc_pkg::OP_LOAD;
            case ($urandom_range(0, 3))
                0: load = 16'h7FFF;
                1: load = 16'h8000;
                default: ;
            endcase
        end else begin
            op = qcc_pkg::OP_NONE;
        end
        q = {pb[sel_b], pb[sel_a]};
        walk_pos = (q == 2'd2) ? 3 : (q == 2'd3) ? 2 : int'(q);
        port = pb;
    endtask

    // Receiver: random or no stall per result, plus one long hold-off on request.
    initial begin
        int gap;
        while (!i_rst_n) @(negedge i_clk);
        forever begin
            gap = rx_idle ? $urandom_range(0, 15) : 0;
            if (hold_req) begin
                gap = HoldCycles;
                hold_req = 1'b0;
            end
            if (gap > 0) begin
                @(negedge i_clk);
                m_axis_tready <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!(m_axis_tvalid && m_axis_tready)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        qcc_pkg::t_state exp_res;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_counts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction: count %0d phase %0d",
                             $signed(m_axis_tdata[15:0]), m_axis_tdata[18:16]);
            end else begin
                exp_res = pending_counts.pop_front();
                if (exp_res.count != m_axis_tdata[15:0] ||
                        exp_res.phase != m_axis_tdata[18:16]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: count exp %0d got %0d, phase exp %0d got %0d",
                                 $signed(exp_res.count), $signed(m_axis_tdata[15:0]),
                                 exp_res.phase, m_axis_tdata[18:16]);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WatchdogLimit) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        qcc_pkg::t_opcode op;
        logic [7:0] port;
        logic [15:0] load;
        int lo;
        int hi;
        int t;

        directed_tbl = '{
            '{qcc_pkg::OP_NONE,   8'h00, 16'h0000, 1'b1, {16'h0000, 3'd1}},
            '{qcc_pkg::OP_UPDATE, 8'h02, 16'h0000, 1'b0, '0},
            '{qcc_pkg::OP_UPDATE, 8'h00, 16'hFFFF, 1'b0, '0},
            '{qcc_pkg::OP_LOAD,   8'h00, 16'h7FFF, 1'b1, {16'h7FFF, 3'd1}},
            '{qcc_pkg::OP_UPDATE, 8'h01, 16'h0000, 1'b0, '0},
            '{qcc_pkg::OP_UPDATE, 8'h03, 16'h0000, 1'b0, '0},
            '{qcc_pkg::OP_UPDATE, 8'h02, 16'h0000, 1'b0, '0},
            '{qcc_pkg::OP_UPDATE, 8'hFC, 16'h0000, 1'b0, '0},
            '{qcc_pkg::OP_LOAD,   8'hFF, 16'h8000, 1'b1, {16'h8000, 3'd1}},
            '{qcc_pkg::OP_UPDATE, 8'h02, 16'h0000, 1'b0, '0},
            '{qcc_pkg::OP_UPDATE, 8'hFD, 16'h0000, 1'b0, '0},
            '{qcc_pkg::OP_UPDATE, 8'h00, 16'h0000, 1'b0, '0},
            '{qcc_pkg::OP_UPDATE, 8'hFF, 16'h0000, 1'b0, '0},
            '{qcc_pkg::OP_INIT,   8'hFE, 16'h7FFF, 1'b1, {16'h0000, 3'd4}},
            '{qcc_pkg::OP_NONE,   8'hFF, 16'h7FFF, 1'b1, {16'h0000, 3'd4}},
            '{qcc_pkg::OP_UPDATE, 8'h00, 16'h0000, 1'b0, '0},
            '{qcc_pkg::OP_UPDATE, 8'h03, 16'h0000, 1'b0, '0},
            '{qcc_pkg::OP_UPDATE, 8'h01, 16'h0000, 1'b0, '0},
            '{qcc_pkg::OP_UPDATE, 8'h02, 16'h0000, 1'b0, '0},
            '{qcc_pkg::OP_LOAD,   8'h00, 16'h1234, 1'b0, '0},
            '{qcc_pkg::OP_INIT,   8'h01, 16'h8000, 1'b1, {16'h0000, 3'd2}},
            '{qcc_pkg::OP_UPDATE, 8'hAA, 16'h0000, 1'b0, '0},
            '{qcc_pkg::OP_UPDATE, 8'h55, 16'h0000, 1'b0, '0}
        };

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < NumDirected; i++)
            send_sample(directed_tbl[i].op, directed_tbl[i].port, directed_tbl[i].load,
                        directed_tbl[i].typed, directed_tbl[i].want);
        drain_results();

        for (int k = 0; k < NumPhases; k++) begin
            case (k)
                0: configure(7, 0, -32768, 32767);
                1: configure(3, 3, -4, 4);
                2: configure(0, 7, 32767, -32768);
                3: configure($urandom_range(0, 7), $urandom_range(0, 7), 0, 0);
                4: configure($urandom_range(0, 7), $urandom_range(0, 7), -32768, -32768);
                5: configure($urandom_range(0, 7), $urandom_range(0, 7), 32767, 32767);
                default: begin
                    if ($urandom_range(0, 1) == 0) begin
                        lo = -$urandom_range(0, 6);
                        hi = $urandom_range(0, 6);
                    end else begin
                        lo = $signed(16'($urandom_range(0, 65535)));
                        hi = $signed(16'($urandom_range(0, 65535)));
                        if (lo > hi) begin
                            t = lo;
                            lo = hi;
                            hi = t;
                        end
                    end
                    configure($urandom_range(0, 7), $urandom_range(0, 7), lo, hi);
                end
            endcase
            tx_idle = (k % 4 == 0) || (k % 4 == 2);
            rx_idle = (k % 4 == 0) || (k % 4 == 3);
            if (k == 5) hold_req = 1'b1;
            for (int n = 0; n < ItemsPerPhase; n++) begin
                if (k == 7 && n == ItemsPerPhase / 2) drain_results();
                make_sample(op, port, load);
                send_sample(op, port, load, 1'b0, '0);
            end
            drain_results();
        end

        if (mismatches == 0 && pending_counts.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
